// File: rtl/source_text_tokenizer_macros.svh
// assertion macros shared by the tokenizer modules
// all of them sample on clk and are quiet while arst_n is low
`ifndef SOURCE_TEXT_TOKENIZER_MACROS_SVH
`define SOURCE_TEXT_TOKENIZER_MACROS_SVH

// condition and consequence in the same cycle
`define STT_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequence in the cycle after the condition
`define STT_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/stt_pkg.sv
`timescale 1ns / 1ps

package stt_pkg;

	localparam int DEF_POSITION_BITS = 32;
	localparam int DEF_LENGTH_BITS   = 16;

	// token queue between scanner and output stage, power of two
	localparam int QUEUE_DEPTH = 4;

	typedef logic [4:0] kind_t;

	localparam kind_t K_IDENT    = 5'd0;
	localparam kind_t K_NUMBER   = 5'd1;
	localparam kind_t K_KW_FIRST = 5'd2;
	localparam kind_t K_LT       = 5'd13;
	localparam kind_t K_GT       = 5'd14;
	localparam kind_t K_EQUAL    = 5'd15;
	localparam kind_t K_PLUS     = 5'd16;
	localparam kind_t K_MINUS    = 5'd17;
	localparam kind_t K_STAR     = 5'd18;
	localparam kind_t K_SLASH    = 5'd19;
	localparam kind_t K_ASSIGN   = 5'd20;
	localparam kind_t K_COMMA    = 5'd21;
	localparam kind_t K_DOT      = 5'd22;
	localparam kind_t K_SEMI     = 5'd23;
	localparam kind_t K_COLON    = 5'd24;
	localparam kind_t K_LPAREN   = 5'd25;
	localparam kind_t K_RPAREN   = 5'd26;
	localparam kind_t K_ERROR    = 5'd27;

	typedef struct packed {
		logic [7:0] char_code;
		logic       end_of_text;
	} in_item_t;

	typedef struct packed {
		kind_t       token_kind;
		logic [31:0] start_position;
		logic [15:0] lexeme_length;
		logic        last_of_item;
	} out_item_t;

	// queued token; identifiers keep their first seven characters
	typedef struct packed {
		kind_t       kind;
		logic [31:0] start;
		logic [15:0] len;
		logic [55:0] prefix;
		logic        last;
	} tok_t;

endpackage

// File: rtl/stt_front.sv
`timescale 1ns / 1ps
`include "source_text_tokenizer_macros.svh"

module stt_front import stt_pkg::*; #(
	parameter int POSITION_BITS = DEF_POSITION_BITS,
	parameter int LENGTH_BITS   = DEF_LENGTH_BITS
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       src_valid,
	output logic       src_ready,
	input  in_item_t   src_data,
	input  logic       room,
	output logic [1:0] push_cnt,
	output tok_t       push0,
	output tok_t       push1
);

	localparam int LEN_W = (LENGTH_BITS > 16) ? 16 : LENGTH_BITS;
	localparam logic [LEN_W-1:0] LEN_MAX = '1;

	localparam logic [2:0] MODE_IDLE   = 3'd0;
	localparam logic [2:0] MODE_IDENT  = 3'd1;
	localparam logic [2:0] MODE_NUMBER = 3'd2;
	localparam logic [2:0] MODE_EQUAL  = 3'd3;
	localparam logic [2:0] MODE_ERROR  = 3'd4;

	logic [2:0]               mode_q, mode_d;
	logic [POSITION_BITS-1:0] start_q, start_d, pos_q;
	logic [LEN_W-1:0]         len_q, len_d, ext_len;
	logic [55:0]              prefix_q, prefix_d, ext_prefix;

	logic [7:0] c;
	logic       is_space, is_alpha, is_digit, is_under, is_eq, is_gt, is_bad;
	logic       single_hit;
	kind_t      single_kind;
	logic       cont, assign_hit, accept;
	logic       a_v, b_v, c_v;
	tok_t       a_tok, b_tok, c_tok;

	function automatic kind_t mode_kind(input logic [2:0] m);
		kind_t k;
		unique case (m)
			MODE_NUMBER: k = K_NUMBER;
			MODE_EQUAL:  k = K_EQUAL;
			MODE_ERROR:  k = K_ERROR;
			default:     k = K_IDENT;
		endcase
		return k;
	endfunction

	assign src_ready = room;
	assign accept    = src_valid && room;
	assign c         = src_data.char_code;

	// character classes
	assign is_space = (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
	assign is_alpha = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
	assign is_digit = (c >= 8'h30 && c <= 8'h39);
	assign is_under = (c == 8'h5F);
	assign is_eq    = (c == 8'h3D);
	assign is_gt    = (c == 8'h3E);

	always_comb begin
		single_hit  = 1'b1;
		single_kind = K_LT;
		unique case (c)
			8'h3C:   single_kind = K_LT;
			8'h3E:   single_kind = K_GT;
			8'h2B:   single_kind = K_PLUS;
			8'h2D:   single_kind = K_MINUS;
			8'h2A:   single_kind = K_STAR;
			8'h2F:   single_kind = K_SLASH;
			8'h2C:   single_kind = K_COMMA;
			8'h2E:   single_kind = K_DOT;
			8'h3B:   single_kind = K_SEMI;
			8'h3A:   single_kind = K_COLON;
			8'h28:   single_kind = K_LPAREN;
			8'h29:   single_kind = K_RPAREN;
			default: single_hit  = 1'b0;
		endcase
	end

	assign is_bad = !(is_space || is_alpha || is_digit || is_under || is_eq || single_hit);

	assign cont = ((mode_q == MODE_IDENT) && (is_alpha || is_digit || is_under))
		|| ((mode_q == MODE_NUMBER) && is_digit)
		|| ((mode_q == MODE_ERROR) && is_bad);
	assign assign_hit = (mode_q == MODE_EQUAL) && is_gt;

	// append the character to the pending token
	always_comb begin
		ext_prefix = prefix_q;
		for (int i = 0; i < 7; i++) begin
			if (len_q == LEN_W'(i)) begin
				ext_prefix[8*i +: 8] = c;
			end
		end
		ext_len = (len_q != LEN_MAX) ? len_q + 1'b1 : len_q;
	end

	always_comb begin
		mode_d   = mode_q;
		start_d  = start_q;
		len_d    = len_q;
		prefix_d = prefix_q;
		a_v      = 1'b0;
		b_v      = 1'b0;

		a_tok        = '0;
		a_tok.kind   = mode_kind(mode_q);
		a_tok.start  = 32'(start_q);
		a_tok.len    = 16'(len_q);
		a_tok.prefix = prefix_q;

		b_tok       = '0;
		b_tok.kind  = single_kind;
		b_tok.start = 32'(pos_q);
		b_tok.len   = 16'd1;

		if (cont) begin
			len_d    = ext_len;
			prefix_d = ext_prefix;
		end else if (assign_hit) begin
			a_v        = 1'b1;
			a_tok.kind = K_ASSIGN;
			a_tok.len  = 16'd2;
			mode_d     = MODE_IDLE;
		end else begin
			a_v = (mode_q == MODE_IDENT) || (mode_q == MODE_NUMBER)
				|| (mode_q == MODE_EQUAL) || (mode_q == MODE_ERROR);
			mode_d = MODE_IDLE;
			if (!is_space) begin
				if (single_hit) begin
					b_v = 1'b1;
				end else begin
					start_d  = pos_q;
					len_d    = LEN_W'(1);
					prefix_d = {48'd0, c};
					priority if (is_alpha || is_under) begin
						mode_d = MODE_IDENT;
					end else if (is_digit) begin
						mode_d = MODE_NUMBER;
					end else if (is_eq) begin
						mode_d = MODE_EQUAL;
					end else begin
						mode_d = MODE_ERROR;
					end
				end
			end
		end

		// end of text flushes whatever is pending after this character
		c_v          = src_data.end_of_text && (mode_d != MODE_IDLE);
		c_tok        = '0;
		c_tok.kind   = mode_kind(mode_d);
		c_tok.start  = 32'(start_d);
		c_tok.len    = 16'(len_d);
		c_tok.prefix = prefix_d;
	end

	// pack the up to two tokens in order
	always_comb begin
		push0    = a_v ? a_tok : (b_v ? b_tok : c_tok);
		push1    = (a_v && b_v) ? b_tok : c_tok;
		push_cnt = 2'({1'b0, a_v} + {1'b0, b_v} + {1'b0, c_v});
		if (!accept) begin
			push_cnt = 2'd0;
		end
		push0.last = (push_cnt == 2'd1);
		push1.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			pos_q    <= '0;
			start_q  <= '0;
			len_q    <= '0;
			prefix_q <= '0;
		end else if (accept) begin
			start_q  <= start_d;
			len_q    <= len_d;
			prefix_q <= prefix_d;
			if (src_data.end_of_text) begin
				mode_q <= MODE_IDLE;
				pos_q  <= '0;
			end else begin
				mode_q <= mode_d;
				pos_q  <= pos_q + 1'b1;
			end
		end
	end

	`STT_ASSERT_NEXT(a_eot_restart, accept && src_data.end_of_text, mode_q == MODE_IDLE && pos_q == '0, "scanner not restarted after end of text")
	`STT_ASSERT_NOW(a_no_push_no_room, !room, push_cnt == 2'd0, "token pushed without queue room")

endmodule

// File: rtl/stt_queue.sv
`timescale 1ns / 1ps
`include "source_text_tokenizer_macros.svh"

module stt_queue import stt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [1:0] push_cnt,
	input  tok_t       push0,
	input  tok_t       push1,
	output logic       room,
	output logic       head_valid,
	output tok_t       head,
	input  logic       pop
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	tok_t             entries_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	// two free entries are needed for the worst case character
	assign room       = (count_q <= CNT_W'(QUEUE_DEPTH - 2));
	assign head_valid = (count_q != '0);
	assign head       = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) begin
			entries_q[wr_ptr_q] <= push0;
		end
		if (push_cnt == 2'd2) begin
			entries_q[wr_ptr_q + 1'b1] <= push1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push_cnt);
			rd_ptr_q <= rd_ptr_q + PTR_W'(pop);
			count_q  <= count_q + CNT_W'(push_cnt) - CNT_W'(pop);
		end
	end

	`STT_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_W'(QUEUE_DEPTH), "queue count beyond depth")
	`STT_ASSERT_NOW(a_pop_nonempty, pop, count_q != '0, "pop from empty queue")
	`STT_ASSERT_NEXT(a_double_push, push_cnt == 2'd2 && !pop, count_q == $past(count_q) + CNT_W'(2), "double push lost")

endmodule

// File: rtl/stt_emit.sv
`timescale 1ns / 1ps

module stt_emit import stt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      head_valid,
	input  tok_t      head,
	output logic      pop,
	output logic      tok_valid,
	input  logic      tok_ready,
	output out_item_t tok_data
);

	localparam int NUM_KW = 11;

	// keyword text right-justified, first character in the top byte used
	localparam logic [55:0] KW_TEXT [NUM_KW] = '{
		56'("begin"), 56'("end"), 56'("label"), 56'("integer"), 56'("goto"),
		56'("if"), 56'("then"), 56'("else"), 56'("fi"), 56'("output"), 56'("input")
	};
	localparam int KW_LEN [NUM_KW] = '{5, 3, 5, 7, 4, 2, 4, 4, 2, 6, 5};

	logic      valid_q;
	out_item_t data_q;
	kind_t     kind_res;

	function automatic kind_t kw_lookup(input logic [55:0] prefix, input logic [15:0] len);
		kind_t k;
		logic  same;
		int    idx;
		k = K_IDENT;
		for (int w = NUM_KW - 1; w >= 0; w--) begin
			same = (len == 16'(KW_LEN[w]));
			for (int i = 0; i < 7; i++) begin
				if (i < KW_LEN[w]) begin
					idx = 8 * (KW_LEN[w] - 1 - i);
					if (prefix[8*i +: 8] != KW_TEXT[w][idx +: 8]) begin
						same = 1'b0;
					end
				end
			end
			if (same) begin
				k = 5'(K_KW_FIRST + w);
			end
		end
		return k;
	endfunction

	assign kind_res  = (head.kind == K_IDENT) ? kw_lookup(head.prefix, head.len) : head.kind;
	assign pop       = head_valid && (!valid_q || tok_ready);
	assign tok_valid = valid_q;
	assign tok_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || tok_ready) begin
			valid_q <= head_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			data_q.token_kind     <= kind_res;
			data_q.start_position <= head.start;
			data_q.lexeme_length  <= head.len;
			data_q.last_of_item   <= head.last;
		end
	end

endmodule

// File: rtl/source_text_tokenizer.sv
`timescale 1ns / 1ps

// Streaming tokenizer: one character request per cycle on src, tokens out on
// tok. Identifiers, decimal numbers and runs of bad characters build up over
// several characters; an identifier that spells one of the eleven keywords
// comes out as that keyword, '=' then '>' is the assign delimiter, other
// operators and delimiters come out at once, whitespace is dropped. A
// character with end_of_text set flushes any pending token and restarts the
// position count at zero. Each character yields zero, one or two tokens, and
// the last token a character causes has last_of_item set. The scanner takes
// a character every cycle while the four-entry token queue has two free
// entries; the output register drains one token per cycle while tok_ready
// is high, so the sustained rate is one character per cycle whenever the
// text averages at most one token per character. A token reaches tok via a
// queue entry and then the output register. Positions wrap within
// POSITION_BITS, lengths saturate at min(2^LENGTH_BITS-1, 65535).
module source_text_tokenizer import stt_pkg::*; #(
	parameter int POSITION_BITS = DEF_POSITION_BITS,
	parameter int LENGTH_BITS   = DEF_LENGTH_BITS
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      src_valid,
	output logic      src_ready,
	input  in_item_t  src_data,
	output logic      tok_valid,
	input  logic      tok_ready,
	output out_item_t tok_data
);

	// scanner to queue
	logic [1:0] push_cnt;
	tok_t       push0, push1;
	logic       room;

	// queue to output stage
	logic head_valid;
	tok_t head;
	logic pop;

	// front: classifies each character and tracks the pending token
	stt_front #(
		.POSITION_BITS(POSITION_BITS),
		.LENGTH_BITS  (LENGTH_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.src_valid(src_valid),
		.src_ready(src_ready),
		.src_data (src_data),
		.room     (room),
		.push_cnt (push_cnt),
		.push0    (push0),
		.push1    (push1)
	);

	// short queue so the scanner and the consumer stall independently
	stt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_cnt  (push_cnt),
		.push0     (push0),
		.push1     (push1),
		.room      (room),
		.head_valid(head_valid),
		.head      (head),
		.pop       (pop)
	);

	// back: keyword match on identifiers and the output register
	stt_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head      (head),
		.pop       (pop),
		.tok_valid (tok_valid),
		.tok_ready (tok_ready),
		.tok_data  (tok_data)
	);

endmodule
